// ===== rtl/core/ris_pkg.sv =====
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types and constants of the rule interest score block.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int SCORE_BITS     = 48;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_BITS     = 32;
  localparam int OPND_BITS      = FIELD_BITS + 1;
  localparam int NUM_BITS       = 2 * OPND_BITS;
  localparam int DEN_BITS       = 2 * OPND_BITS + 1;
  localparam int ADDR_BITS      = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int OUT_DEPTH      = 2;

  // Measure selected by the mode register
  typedef enum logic [2:0] {
    MODE_CONF = 3'd0,
    MODE_LIFT = 3'd1,
    MODE_ALLC = 3'd2,
    MODE_MAXC = 3'd3,
    MODE_KULC = 3'd4,
    MODE_COS  = 3'd5,
    MODE_CONV = 3'd6
  } ris_mode_t;

  // Register index, taken from paddr[2]
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_TCOUNT = 1'b1;

  typedef struct packed {
    logic squared;
    logic zero_div;
    logic zero_out;
  } ris_flags_t;

  // Request handed from the front to the back
  typedef struct packed {
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
    ris_flags_t          flags;
  } ris_op_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic                  saturated;
  } ris_res_t;

endpackage

// ===== rtl/core/rule_interest_score.sv =====
// ----------------------------------------------------------------------------
// rule_interest_score
// Scores association rules with one of seven interestingness measures.
// ----------------------------------------------------------------------------
// Throughput: one rule per cycle; the bit-per-stage divider and root pipelines
// each take a new request every cycle and stall together only when results back up.
// Reset: synchronous, rst_n low clears all queues and stage valids, mode to
// confidence and the transaction count to 1.
module rule_interest_score #(
  parameter int COUNT_BITS = ris_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = ris_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [ris_pkg::FIELD_BITS-1:0]   in_antecedent_support,
  input  logic [ris_pkg::FIELD_BITS-1:0]   in_consequent_support,
  input  logic [ris_pkg::FIELD_BITS-1:0]   in_joint_support,
  output logic                             empty,
  input  logic                             pop,
  output logic [ris_pkg::SCORE_BITS-1:0]   out_score_value,
  output logic                             out_saturated,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ris_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [ris_pkg::FIELD_BITS-1:0]   pwdata,
  output logic [ris_pkg::FIELD_BITS-1:0]   prdata,
  output logic                             pready
);
  import ris_pkg::*;

  logic [2:0]            mode_r;
  logic [FIELD_BITS-1:0] tcount_r;
  logic                  wr_en;

  logic                  f_valid, q_full, q_empty, q_pop;
  ris_op_t               f_op, q_op;
  logic                  b_valid, o_full;
  ris_res_t              b_res, o_res;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CONF;
      tcount_r <= FIELD_BITS'(1);
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE:   mode_r   <= pwdata[2:0];
        REG_TCOUNT: tcount_r <= pwdata;
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_TCOUNT) ? tcount_r : FIELD_BITS'(mode_r);

  ris_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_a     (in_antecedent_support),
    .in_c     (in_consequent_support),
    .in_j     (in_joint_support),
    .mode     (mode_r),
    .tcount   (tcount_r),
    .op_valid (f_valid),
    .op_ready (!q_full),
    .op       (f_op)
  );

  ris_fifo #(.W($bits(ris_op_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data (f_op),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_op),
    .empty   (q_empty)
  );

  ris_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!q_empty),
    .op_pop    (q_pop),
    .op        (q_op),
    .res_valid (b_valid),
    .res_ready (!o_full),
    .res       (b_res)
  );

  ris_fifo #(.W($bits(ris_res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (b_valid),
    .wr_data (b_res),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_res),
    .empty   (empty)
  );

  assign out_score_value = o_res.score;
  assign out_saturated   = o_res.saturated;
endmodule

// ===== rtl/core/ris_fifo.sv =====
// ----------------------------------------------------------------------------
// ris_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module ris_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]   rd_ptr_r, rd_ptr_nxt;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]) && (wr_ptr_r[AW] != rd_ptr_r[AW]);
  assign rd_data = mem_r[rd_ptr_r[AW-1:0]];

  // Advance pointers on each write while not full and each read while not empty
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (AW+1)'(wr_en && !full);
    rd_ptr_nxt = rd_ptr_r + (AW+1)'(rd_en && !empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end
endmodule

// ===== rtl/core/ris_front.sv =====
// ----------------------------------------------------------------------------
// ris_front
// Accepts rules, classifies the measure and forms numerator and divisor.
// ----------------------------------------------------------------------------
module ris_front #(
  parameter int COUNT_BITS = ris_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [ris_pkg::FIELD_BITS-1:0]  in_a,
  input  logic [ris_pkg::FIELD_BITS-1:0]  in_c,
  input  logic [ris_pkg::FIELD_BITS-1:0]  in_j,
  input  logic [2:0]                      mode,
  input  logic [ris_pkg::FIELD_BITS-1:0]  tcount,
  output logic                            op_valid,
  input  logic                            op_ready,
  output ris_pkg::ris_op_t                op
);
  import ris_pkg::*;

  localparam logic [FIELD_BITS-1:0] CMASK = (COUNT_BITS >= FIELD_BITS) ? '1 :
      FIELD_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  logic [FIELD_BITS-1:0] a, c, j, amax, amin, tc, aj;
  logic                  num_neg, den_neg, conv_div;
  logic                  accept, f_adv;

  logic                  f1_v_r, f1_v_nxt, f2_v_r, f2_v_nxt;
  logic [OPND_BITS-1:0]  nx_r, ny_r, dx_r, dy_r, nx_nxt, ny_nxt, dx_nxt, dy_nxt;
  logic                  dshl_r, dshl_nxt;
  ris_flags_t            fl1_r, fl1_nxt, fl2_r;
  logic [NUM_BITS-1:0]   num_r;
  logic [NUM_BITS-1:0]   dprod;
  logic [DEN_BITS-1:0]   den_r;

  assign f_adv  = !f2_v_r || op_ready;
  assign full   = f1_v_r && !f_adv;
  assign accept = push && !full;

  // Classify the rule and pick multiplier operands
  always_comb begin
    a        = in_a & CMASK;
    c        = in_c & CMASK;
    j        = in_j & CMASK;
    amax     = (a > c) ? a : c;
    amin     = (a < c) ? a : c;
    num_neg  = c > tcount;
    den_neg  = j > a;
    tc       = num_neg ? c - tcount : tcount - c;
    aj       = den_neg ? j - a : a - j;
    conv_div = (a == j) || (a == '0) || (tcount == '0);
    nx_nxt   = OPND_BITS'(j);
    ny_nxt   = OPND_BITS'(1);
    dx_nxt   = OPND_BITS'(a);
    dy_nxt   = OPND_BITS'(1);
    dshl_nxt = 1'b0;
    fl1_nxt  = '0;
    case (mode)
      MODE_CONF: begin
        fl1_nxt.zero_div = (a == '0);
      end
      MODE_LIFT: begin
        ny_nxt           = OPND_BITS'(tcount);
        dy_nxt           = OPND_BITS'(c);
        fl1_nxt.zero_div = (a == '0) || (c == '0);
      end
      MODE_ALLC: begin
        dx_nxt           = OPND_BITS'(amax);
        fl1_nxt.zero_div = (a == '0) && (c == '0);
      end
      MODE_MAXC: begin
        dx_nxt           = OPND_BITS'(amin);
        fl1_nxt.zero_div = (a == '0) || (c == '0);
      end
      MODE_KULC: begin
        ny_nxt           = OPND_BITS'(a) + OPND_BITS'(c);
        dy_nxt           = OPND_BITS'(c);
        dshl_nxt         = 1'b1;
        fl1_nxt.zero_div = (a == '0) || (c == '0);
      end
      MODE_COS: begin
        ny_nxt           = OPND_BITS'(j);
        dy_nxt           = OPND_BITS'(c);
        fl1_nxt.squared  = 1'b1;
        fl1_nxt.zero_div = (a == '0) || (c == '0);
      end
      MODE_CONV: begin
        nx_nxt           = OPND_BITS'(a);
        ny_nxt           = OPND_BITS'(tc);
        dx_nxt           = OPND_BITS'(tcount);
        dy_nxt           = OPND_BITS'(aj);
        fl1_nxt.zero_div = conv_div;
        fl1_nxt.zero_out = !conv_div && ((tc == '0) || (num_neg != den_neg));
      end
      default: begin
        fl1_nxt.zero_out = 1'b1;
      end
    endcase
  end

  // Stage valids: first stage refills when it empties or moves on
  always_comb begin
    f1_v_nxt = accept ? 1'b1 : (f_adv ? 1'b0 : f1_v_r);
    f2_v_nxt = f_adv ? f1_v_r : f2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
      f2_v_r <= f2_v_nxt;
    end
  end

  // Hold operands, then multiply
  assign dprod = dx_r * dy_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      dshl_r <= dshl_nxt;
      fl1_r  <= fl1_nxt;
    end
    if (f_adv) begin
      num_r <= nx_r * ny_r;
      den_r <= dshl_r ? {dprod, 1'b0} : {1'b0, dprod};
      fl2_r <= fl1_r;
    end
  end

  assign op_valid  = f2_v_r;
  assign op.num    = num_r;
  assign op.den    = den_r;
  assign op.flags  = fl2_r;
endmodule

// ===== rtl/core/ris_back.sv =====
// ----------------------------------------------------------------------------
// ris_back
// Pipelined long divider followed by a pipelined square root, one bit a stage.
// ----------------------------------------------------------------------------
module ris_back #(
  parameter int FRAC_BITS = ris_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  output logic              op_pop,
  input  ris_pkg::ris_op_t  op,
  output logic              res_valid,
  input  logic              res_ready,
  output ris_pkg::ris_res_t res
);
  import ris_pkg::*;

  localparam int DW = NUM_BITS + 2 * FRAC_BITS;
  localparam int RW = DW / 2;
  localparam int SW = RW + 2;

  logic adv;

  // Divider stages: 0 holds the loaded request
  logic                dv_r  [DW+1];
  ris_flags_t          dfl_r [DW+1];
  logic [DEN_BITS-1:0] den_r [DW+1];
  logic [DEN_BITS-1:0] rem_r [DW+1];
  logic [DW-1:0]       dq_r  [DW+1];

  // Root stages, inputs and registers
  logic                sv_in   [RW];
  ris_flags_t          sfl_in  [RW];
  logic [DW-1:0]       rad_in  [RW];
  logic [RW-1:0]       root_in [RW];
  logic [SW-1:0]       srem_in [RW];
  logic                sv_r    [RW];
  ris_flags_t          sfl_r   [RW];
  logic [DW-1:0]       rad_r   [RW];
  logic [RW-1:0]       root_r  [RW];
  logic [SW-1:0]       srem_r  [RW];

  logic [DW-1:0]       val;

  assign adv    = !sv_r[RW-1] || res_ready;
  assign op_pop = adv && op_valid;

  // Load the scaled dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dfl_r[0] <= op.flags;
      den_r[0] <= op.den;
      rem_r[0] <= '0;
      dq_r[0]  <= op.flags.squared ? DW'({op.num, {(2*FRAC_BITS){1'b0}}}) :
                                     DW'({op.num, {FRAC_BITS{1'b0}}});
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DEN_BITS:0] sh;
    logic              ge;
    logic [DEN_BITS:0] diff;

    assign sh   = {rem_r[k], dq_r[k][DW-1]};
    assign ge   = sh >= {1'b0, den_r[k]};
    assign diff = sh - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dfl_r[k+1] <= dfl_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= ge ? diff[DEN_BITS-1:0] : sh[DEN_BITS-1:0];
        dq_r[k+1]  <= {dq_r[k][DW-2:0], ge};
      end
    end
  end

  // One root bit per stage; plain quotients pass through unchanged
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SW+1:0] sh;
    logic [SW+1:0] trial;
    logic          ge;
    logic [SW+1:0] diff;

    if (k == 0) begin : g_first
      assign sv_in[k]   = dv_r[DW];
      assign sfl_in[k]  = dfl_r[DW];
      assign rad_in[k]  = dq_r[DW];
      assign root_in[k] = '0;
      assign srem_in[k] = '0;
    end else begin : g_next
      assign sv_in[k]   = sv_r[k-1];
      assign sfl_in[k]  = sfl_r[k-1];
      assign rad_in[k]  = rad_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign srem_in[k] = srem_r[k-1];
    end

    assign sh    = {srem_in[k], rad_in[k][DW-1:DW-2]};
    assign trial = (SW+2)'({root_in[k], 2'b01});
    assign ge    = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (adv) begin
        sv_r[k] <= sv_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sfl_r[k] <= sfl_in[k];
        if (sfl_in[k].squared) begin
          rad_r[k]  <= {rad_in[k][DW-3:0], 2'b00};
          root_r[k] <= {root_in[k][RW-2:0], ge};
          srem_r[k] <= ge ? diff[SW-1:0] : sh[SW-1:0];
        end else begin
          rad_r[k]  <= rad_in[k];
          root_r[k] <= root_in[k];
          srem_r[k] <= srem_in[k];
        end
      end
    end
  end

  // Clamp and apply the special cases
  always_comb begin
    val = sfl_r[RW-1].squared ? DW'(root_r[RW-1]) : rad_r[RW-1];
    res.saturated = 1'b0;
    if (sfl_r[RW-1].zero_div) begin
      res.score     = '1;
      res.saturated = 1'b1;
    end else if (sfl_r[RW-1].zero_out) begin
      res.score = '0;
    end else if (val[DW-1:SCORE_BITS] != '0) begin
      res.score = '1;
    end else begin
      res.score = val[SCORE_BITS-1:0];
    end
  end

  assign res_valid = sv_r[RW-1];
endmodule

// ===== rtl/core/ris_sva.sv =====
// ----------------------------------------------------------------------------
// ris_sva
// Port-level checks of the rule interest score block, bound to the top level.
// ----------------------------------------------------------------------------
module ris_sva (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [ris_pkg::SCORE_BITS-1:0] out_score_value,
  input logic                           out_saturated
);
  import ris_pkg::*;

  logic [15:0] cnt_r;

  // Track requests still owed a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 16'(push && !full) - 16'(pop && !empty);
    end
  end

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) |-> (cnt_r != '0))
    else $error("result without pending request");

  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_saturated) |-> (out_score_value == '1))
    else $error("saturated score not at maximum");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_score_value) && $stable(out_saturated)))
    else $error("waiting result changed");
endmodule

bind rule_interest_score ris_sva u_ris_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_score_value (out_score_value),
  .out_saturated   (out_saturated)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rule_interest_score: drives rule support counts
// through all seven measures under several register settings, predicts each
// score with exact wide integer arithmetic and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ris_pkg::*;

  localparam int FRAC = 16;
  localparam logic [47:0] SCORE_MAX = {48{1'b1}};

  typedef struct {
    logic [47:0] score;
    logic        sat;
  } score_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts scores and holds them until they come out
  // --------------------------------------------------------------------------
  class score_board;
    logic [2:0]  mode;
    logic [31:0] tcount;
    score_t      pending[$];
    int          errors;

    function new();
      mode = MODE_CONF;
      tcount = 32'd1;
      errors = 0;
    endfunction

    // Largest s below 2^48 with s*den (or s*s*den) not above num
    function logic [47:0] floor_div(logic [255:0] num, logic [255:0] den, bit sq);
      logic [47:0]  s;
      logic [47:0]  t;
      logic [255:0] p;
      s = '0;
      for (int b = 47; b >= 0; b--) begin
        t = s | (48'd1 << b);
        p = sq ? (256'(t) * 256'(t)) * den : 256'(t) * den;
        if (p <= num) s = t;
      end
      return s;
    endfunction

    function score_t predict(logic [31:0] a, logic [31:0] c, logic [31:0] j);
      score_t       r;
      logic [255:0] num;
      logic [255:0] den;
      logic [63:0]  tc;
      logic [63:0]  aj;
      bit           zdiv;
      bit           zout;
      bit           sq;
      zdiv = 0;
      zout = 0;
      sq = 0;
      num = '0;
      den = 256'd1;
      case (mode)
        MODE_CONF: begin
          num = 256'(j); den = 256'(a); zdiv = (a == 0);
        end
        MODE_LIFT: begin
          num = 256'(j) * 256'(tcount); den = 256'(a) * 256'(c);
          zdiv = (a == 0 || c == 0);
        end
        MODE_ALLC: begin
          num = 256'(j); den = 256'((a > c) ? a : c); zdiv = (a == 0 && c == 0);
        end
        MODE_MAXC: begin
          num = 256'(j); den = 256'((a < c) ? a : c); zdiv = (a == 0 || c == 0);
        end
        MODE_KULC: begin
          num = 256'(j) * (256'(a) + 256'(c)); den = (256'(a) * 256'(c)) << 1;
          zdiv = (a == 0 || c == 0);
        end
        MODE_COS: begin
          num = 256'(j) * 256'(j); den = 256'(a) * 256'(c);
          zdiv = (a == 0 || c == 0); sq = 1;
        end
        MODE_CONV: begin
          tc = (c > tcount) ? 64'(c) - 64'(tcount) : 64'(tcount) - 64'(c);
          aj = (j > a) ? 64'(j) - 64'(a) : 64'(a) - 64'(j);
          zdiv = (a == j || a == 0 || tcount == 0);
          if (!zdiv) begin
            if (tc == 0 || ((c > tcount) != (j > a))) zout = 1;
            num = 256'(a) * 256'(tc); den = 256'(tcount) * 256'(aj);
          end
        end
        default: zout = 1;
      endcase
      if (zdiv) begin
        r.score = SCORE_MAX; r.sat = 1;
      end else if (zout) begin
        r.score = '0; r.sat = 0;
      end else begin
        r.score = floor_div(num << (sq ? 2 * FRAC : FRAC), den, sq); r.sat = 0;
      end
      return r;
    endfunction

    function void note_rule(logic [31:0] a, logic [31:0] c, logic [31:0] j);
      pending = {pending, predict(a, c, j)};
    endfunction

    function void check_score(logic [47:0] score, logic sat);
      score_t e;
      if (pending.size() == 0) begin
        $error("score %h arrived with none expected", score);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (score !== e.score) begin
        $error("score_value expected %h actual %h", e.score, score);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [31:0] in_antecedent_support;
  logic [31:0] in_consequent_support;
  logic [31:0] in_joint_support;
  logic        empty;
  logic        pop;
  logic [47:0] out_score_value;
  logic        out_saturated;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  score_board sb = new();
  int         hold_cycles;
  bit         stim_done;

  rule_interest_score DUT (
    .clk, .rst_n, .push, .full,
    .in_antecedent_support, .in_consequent_support, .in_joint_support,
    .empty, .pop, .out_score_value, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Write one register: setup then access
  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MODE) sb.mode = value[2:0];
    else sb.tcount = value;
  endtask

  // Offer one rule and hold it until accepted
  task automatic send_rule(logic [31:0] a, logic [31:0] c, logic [31:0] j, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_antecedent_support <= a;
    in_consequent_support <= c;
    in_joint_support <= j;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_rule(a, c, j);
  endtask

  task automatic end_burst();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all scores, then let the pipeline drain
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 1000);
      3: return $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  // Random rule: mostly joint not above either side, sometimes equal to antecedent, sometimes anything
  task automatic send_random(bit gaps);
    logic [31:0] a, c, j;
    a = rand_count();
    c = rand_count();
    case ($urandom_range(0, 4))
      0: j = rand_count();
      1: j = a;
      default: j = (a < c ? a : c) == 0 ? 32'd0 : $urandom_range(0, (a < c ? a : c));
    endcase
    send_rule(a, c, j, gaps);
  endtask

  // Result side: check each accepted score, then idle a drawn number of cycles
  initial begin
    int wait_n;
    pop = 1'b0;
    wait_n = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_score(out_score_value, out_saturated);
        wait_n = stim_done ? 0 : $urandom_range(0, 5);
      end
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if (wait_n > 0) begin
        pop <= 1'b0;
        wait_n--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] tvals[4];
    rst_n = 1'b0; push = 1'b0;
    in_antecedent_support = '0; in_consequent_support = '0; in_joint_support = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_cycles = 0; stim_done = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every mode over edge cases, reset settings first
    tvals = '{32'd1, 32'd100, 32'hFFFF_FFFF, 32'd0};
    for (int m = 0; m < 8; m++) begin
      if (m > 0) write_reg(REG_MODE, 32'(m));
      write_reg(REG_TCOUNT, (m == 6) ? 32'd100 : tvals[m % 4]);
      send_rule(0, 0, 0, 0);
      send_rule(10, 20, 5, 0);
      send_rule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_rule(1, 32'hFFFF_FFFF, 1, 0);
      send_rule(50, 200, 60, 0);
      send_rule(0, 5, 3, 0);
      end_burst();
      drain();
    end

    // Random phases across modes and transaction counts; one long hold-off
    // while rules stream back to back fills the block and stalls its input
    for (int ph = 0; ph < 24; ph++) begin
      write_reg(REG_MODE, (ph < 21) ? 32'(ph % 7) : 32'($urandom_range(0, 7)));
      write_reg(REG_TCOUNT, (ph % 4 == 3) ? 32'hFFFF_FFFF : rand_count());
      if (ph == 6) hold_cycles = 300;
      for (int i = 0; i < ((ph == 6) ? 200 : 45); i++) send_random(ph % 3 != 0);
      end_burst();
      drain();
    end

    stim_done = 1;
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
